// ===== hdl/alpha_blend_pixel_writer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend pixel writer
// Clocked on clk_i and disabled while rst_ni is low.
// Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_PIXEL_WRITER_ASSERT_SVH
`define ALPHA_BLEND_PIXEL_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ABPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ABPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ABPW_ASSERT_NOW(lbl, ante, cons, msg)
`define ABPW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/abpw_pkg.sv =====
// ----------------------------------------------------------------------------
// abpw_pkg
// Shared constants and types of the alpha blend pixel writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abpw_pkg;

  // default geometry
  localparam int DEFAULT_STORE_DEPTH = 65536;
  localparam int DEFAULT_COORD_BITS  = 13;

  // configuration registers
  localparam int ROW_WIDTH_W   = 13;
  localparam int PIXEL_COUNT_W = 17;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd1;

  localparam logic [ROW_WIDTH_W-1:0]   ROW_WIDTH_RST   = 13'd256;
  localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 17'd65536;

  // pixel word layout
  localparam int COLOR_W   = 32;
  localparam int ADDRESS_W = 16;
  localparam int STATUS_W  = 2;

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // surface store access request
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } surf_ctrl_t;

endpackage

// ===== hdl/alpha_blend_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// alpha_blend_pixel_writer
// Pixel writer with alpha blending over a cleared 32-bit surface store.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o | x_pos, y_pos, color
//   out     | output    | out_valid_o/out_ready_i | status, address, word
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// A pixel passes through these steps: accept, y*row_width multiply, position add,
// range check and RAM read issue, read latency with blend products, final
// sum and write-back. The sequencer handles one word at a time.
// After reset a clearing sweep zeroes every word of the store;
// in_ready_o stays low until it ends. Config writes are taken at any time.
// The last step waits while the output register holds an untaken word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "alpha_blend_pixel_writer_assert.svh"

module alpha_blend_pixel_writer #(
  parameter int STORE_DEPTH = abpw_pkg::DEFAULT_STORE_DEPTH,
  parameter int COORD_BITS  = abpw_pkg::DEFAULT_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel writes
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        x_pos_i,
  input  logic signed [COORD_BITS-1:0]        y_pos_i,
  input  logic [abpw_pkg::COLOR_W-1:0]        color_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [abpw_pkg::STATUS_W-1:0]       status_o,
  output logic [abpw_pkg::ADDRESS_W-1:0]      address_o,
  output logic [abpw_pkg::COLOR_W-1:0]        stored_word_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abpw_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [abpw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AddrW = $clog2(STORE_DEPTH);
  localparam int PosW  = COORD_BITS + abpw_pkg::ROW_WIDTH_W + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [abpw_pkg::ROW_WIDTH_W-1:0]   row_width_q;
  logic [abpw_pkg::PIXEL_COUNT_W-1:0] pixel_count_q;

  // item registers
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [abpw_pkg::COLOR_W-1:0] color_q;
  logic signed [PosW-1:0]       prod_q;
  logic signed [PosW-1:0]       pos_q;
  logic [abpw_pkg::STATUS_W-1:0] res_status_q;
  logic [AddrW-1:0]             res_addr_q;

  // output register
  logic                          out_valid_q;
  logic [abpw_pkg::STATUS_W-1:0] out_status_q;
  logic [abpw_pkg::ADDRESS_W-1:0] out_addr_q;
  logic [abpw_pkg::COLOR_W-1:0]  out_word_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         pos_bad;
  logic [7:0]                   alpha;
  logic [23:0]                  src_bgr;
  logic [abpw_pkg::COLOR_W-1:0] opaque_word;
  logic [abpw_pkg::COLOR_W-1:0] blend_word;
  logic [abpw_pkg::COLOR_W-1:0] fin_word;
  logic [abpw_pkg::COLOR_W-1:0] rd_data;
  logic                         clr_busy;
  logic                         do_blend;
  abpw_pkg::surf_ctrl_t         surf_ctrl;
  logic [AddrW-1:0]             surf_addr;

  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= abpw_pkg::ROW_WIDTH_RST;
      pixel_count_q <= abpw_pkg::PIXEL_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abpw_pkg::CFG_ROW_WIDTH:   row_width_q   <= cfg_data_i[abpw_pkg::ROW_WIDTH_W-1:0];
        abpw_pkg::CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i[abpw_pkg::PIXEL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // byte views of the held color
  assign alpha       = color_q[7:0];
  assign src_bgr     = {color_q[15:8], color_q[23:16], color_q[31:24]};
  assign opaque_word = {src_bgr, alpha};

  // range check on the registered position
  assign pos_bad = pos_q[PosW-1]
                || ($unsigned(pos_q) >= PosW'(pixel_count_q))
                || ($unsigned(pos_q) >= PosW'(STORE_DEPTH));

  assign do_blend = !pos_bad && (alpha != abpw_pkg::ALPHA_CLEAR)
                 && (alpha != abpw_pkg::ALPHA_OPAQUE);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept) state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = S_CHK;
      S_CHK:  state_d = S_RD;
      S_RD:   state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q     <= x_pos_i;
      y_q     <= y_pos_i;
      color_q <= color_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= PosW'(y_q) * PosW'($signed({1'b0, row_width_q}));
    end
    if (state_q == S_ADD) begin
      pos_q <= PosW'(x_q) + prod_q;
    end
    if (state_q == S_CHK) begin
      if (pos_bad) begin
        res_status_q <= abpw_pkg::ST_RANGE;
        res_addr_q   <= '0;
      end else begin
        res_status_q <= (alpha == abpw_pkg::ALPHA_CLEAR) ? abpw_pkg::ST_SKIPPED
                                                          : abpw_pkg::ST_WRITTEN;
        res_addr_q   <= pos_q[AddrW-1:0];
      end
    end
  end

  // RAM access: read in check step, write-back in final step
  always_comb begin
    surf_ctrl.rd_en = (state_q == S_CHK) && do_blend;
    surf_ctrl.wr_en = (state_q == S_FIN) && out_free
                   && (res_status_q == abpw_pkg::ST_WRITTEN);
    surf_addr       = (state_q == S_CHK) ? pos_q[AddrW-1:0] : res_addr_q;
  end

  abpw_surface #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_surface (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (surf_ctrl),
    .addr_i   (surf_addr),
    .wr_data_i(fin_word),
    .rd_data_o(rd_data),
    .busy_o   (clr_busy)
  );

  abpw_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (state_q == S_RD),
    .src_bgr_i(src_bgr),
    .alpha_i  (alpha),
    .back_i   (rd_data),
    .word_o   (blend_word)
  );

  // final word
  always_comb begin
    if (res_status_q != abpw_pkg::ST_WRITTEN) begin
      fin_word = '0;
    end else if (alpha == abpw_pkg::ALPHA_OPAQUE) begin
      fin_word = opaque_word;
    end else begin
      fin_word = blend_word;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      out_status_q <= res_status_q;
      out_addr_q   <= abpw_pkg::ADDRESS_W'(res_addr_q);
      out_word_q   <= fin_word;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign address_o     = out_addr_q;
  assign stored_word_o = out_word_q;

  // checks
  `ABPW_ASSERT_NOW(a_no_accept_clear, clr_busy, !in_ready_o, "item accepted during clear")
  `ABPW_ASSERT_NEXT(a_accept_busy, in_accept, state_q == S_MUL, "sequencer missed item")
  `ABPW_ASSERT_NOW(a_wr_only_fin, surf_ctrl.wr_en, (state_q == S_FIN) && !clr_busy, "stray write")
  `ABPW_ASSERT_NOW(a_range_zero, out_valid_o && (status_o == abpw_pkg::ST_RANGE),
                   (address_o == '0) && (stored_word_o == '0), "range error not zeroed")

endmodule

// ===== hdl/abpw_surface.sv =====
// ----------------------------------------------------------------------------
// abpw_surface
// Surface store: single-port synchronous RAM with registered read data and a
// clearing sweep after reset that writes zero to every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abpw_surface #(
  parameter int STORE_DEPTH = abpw_pkg::DEFAULT_STORE_DEPTH,
  parameter int AddrW       = $clog2(STORE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  abpw_pkg::surf_ctrl_t        ctrl_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [abpw_pkg::COLOR_W-1:0] wr_data_i,
  output logic [abpw_pkg::COLOR_W-1:0] rd_data_o,
  output logic                        busy_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(STORE_DEPTH - 1);

  logic [abpw_pkg::COLOR_W-1:0] mem_q [STORE_DEPTH];
  logic [abpw_pkg::COLOR_W-1:0] rd_data_q;
  logic                         clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]             clr_addr_q, clr_addr_d;

  logic                         we;
  logic [AddrW-1:0]             waddr;
  logic [abpw_pkg::COLOR_W-1:0] wdata;

  // clear sweep owns the write port until done
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_busy_q | ctrl_i.wr_en;
  assign waddr = clr_busy_q ? clr_addr_q : addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  // RAM array
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// ===== hdl/abpw_blend.sv =====
// ----------------------------------------------------------------------------
// abpw_blend
// Per-channel alpha mix: registered source and background products, then
// the sum of their high bytes. Alpha byte of the result is 255 - a.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abpw_blend (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [23:0]                 src_bgr_i,
  input  logic [7:0]                  alpha_i,
  input  logic [abpw_pkg::COLOR_W-1:0] back_i,
  output logic [abpw_pkg::COLOR_W-1:0] word_o
);

  logic [16:0] src_prod_q [3];
  logic [15:0] back_prod_q [3];
  logic [8:0]  src_wt;
  logic [7:0]  back_wt;
  logic [8:0]  mix [3];

  assign src_wt  = {1'b0, alpha_i} + 9'd1;
  assign back_wt = abpw_pkg::ALPHA_OPAQUE - alpha_i;

  // lane k: src byte k of B,G,R word, background byte k+1 of stored word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        src_prod_q[k]  <= 17'(src_bgr_i[8*k +: 8]) * 17'(src_wt);
        back_prod_q[k] <= 16'(back_i[8*k+8 +: 8]) * 16'(back_wt);
      end
    end
  end

  // high bytes of both products; the sum stays within a byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix[k] = src_prod_q[k][16:8] + {1'b0, back_prod_q[k][15:8]};
    end
  end

  assign word_o = {mix[2][7:0], mix[1][7:0], mix[0][7:0], ~alpha_i};

endmodule

// ===== test/tb_alpha_blend_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// tb_alpha_blend_pixel_writer
// Self-checking bench for the alpha blend pixel writer. A scoreboard keeps
// its own copy of the surface and of both geometry registers, predicts the
// status, address and stored word of every accepted pixel, and compares
// them in order against the result channel. The run covers several
// geometry settings; both sides insert random gaps and stalls but in one stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef logic signed [abpw_pkg::DEFAULT_COORD_BITS-1:0] coord_t;

typedef struct packed {
  logic [abpw_pkg::STATUS_W-1:0]  status;
  logic [abpw_pkg::ADDRESS_W-1:0] address;
  logic [abpw_pkg::COLOR_W-1:0]   stored_word;
} pixel_result_t;

class blend_scoreboard;
  bit [31:0]                          surface_words [abpw_pkg::DEFAULT_STORE_DEPTH];
  bit [abpw_pkg::ROW_WIDTH_W-1:0]     row_width;
  bit [abpw_pkg::PIXEL_COUNT_W-1:0]   pixel_count;
  pixel_result_t                      expected_writes [$];
  int                                 mismatches;

  function new();
    foreach (surface_words[i]) surface_words[i] = '0;
    row_width   = abpw_pkg::ROW_WIDTH_RST;
    pixel_count = abpw_pkg::PIXEL_COUNT_RST;
    mismatches  = 0;
  endfunction

  function void set_register(logic [abpw_pkg::CFG_INDEX_W-1:0] index,
                             logic [abpw_pkg::CFG_DATA_W-1:0] data);
    if (index == abpw_pkg::CFG_ROW_WIDTH) begin
      row_width = data[abpw_pkg::ROW_WIDTH_W-1:0];
    end else if (index == abpw_pkg::CFG_PIXEL_COUNT) begin
      pixel_count = data[abpw_pkg::PIXEL_COUNT_W-1:0];
    end
  endfunction

  // source weight alpha+1, background weight 255-alpha
  function bit [7:0] blend_channel(bit [7:0] src, bit [7:0] back, bit [7:0] alpha);
    int fore_part;
    int back_part;
    fore_part = (int'(src) * (int'(alpha) + 1)) >> 8;
    back_part = (int'(back) * (255 - int'(alpha))) >> 8;
    return 8'(fore_part + back_part);
  endfunction

  // predict the result of one accepted pixel and update the surface copy
  function void note_pixel(coord_t x, coord_t y, logic [31:0] color);
    longint        pos;
    int            idx;
    bit [7:0]      alpha;
    bit [31:0]     back;
    pixel_result_t res;
    pos   = longint'(x) + longint'(y) * longint'(row_width);
    alpha = color[7:0];
    res   = '0;
    if (pos < 0 || pos >= longint'(pixel_count) ||
        pos >= longint'(abpw_pkg::DEFAULT_STORE_DEPTH)) begin
      res.status = abpw_pkg::ST_RANGE;
    end else begin
      idx         = int'(pos);
      res.address = idx[15:0];
      if (alpha == abpw_pkg::ALPHA_CLEAR) begin
        res.status = abpw_pkg::ST_SKIPPED;
      end else begin
        if (alpha == abpw_pkg::ALPHA_OPAQUE) begin
          res.stored_word = {color[15:8], color[23:16], color[31:24], alpha};
        end else begin
          back = surface_words[idx];
          res.stored_word = {blend_channel(color[15:8], back[31:24], alpha),
                             blend_channel(color[23:16], back[23:16], alpha),
                             blend_channel(color[31:24], back[15:8], alpha),
                             8'(8'hFF - alpha)};
        end
        surface_words[idx] = res.stored_word;
        res.status = abpw_pkg::ST_WRITTEN;
      end
    end
    expected_writes.push_back(res);
  endfunction

  function void check_result(logic [abpw_pkg::STATUS_W-1:0] status,
                             logic [abpw_pkg::ADDRESS_W-1:0] address,
                             logic [abpw_pkg::COLOR_W-1:0] stored_word);
    pixel_result_t exp;
    if (expected_writes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("error: result word with nothing expected: status %0d addr %h word %h",
                 status, address, stored_word);
    end else begin
      exp = expected_writes.pop_front();
      if (status !== exp.status || address !== exp.address ||
          stored_word !== exp.stored_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: status %0d/%0d addr %h/%h word %h/%h (expected/actual)",
                   exp.status, status, exp.address, address, exp.stored_word,
                   stored_word);
      end
    end
  endfunction

  function int pending();
    return expected_writes.size();
  endfunction
endclass

module tb_alpha_blend_pixel_writer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [abpw_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  coord_t                           x_pos_i = '0;
  coord_t                           y_pos_i = '0;
  logic [abpw_pkg::COLOR_W-1:0]     color_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [abpw_pkg::STATUS_W-1:0]    status_o;
  logic [abpw_pkg::ADDRESS_W-1:0]   address_o;
  logic [abpw_pkg::COLOR_W-1:0]     stored_word_o;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [abpw_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [abpw_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  blend_scoreboard sb = new();
  bit              no_gaps = 1'b0;
  int              cycle_count = 0;

  alpha_blend_pixel_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .address_o     (address_o),
    .stored_word_o (stored_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(0, 99) >= 7);
  end

  // observe every handshake on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_pixel(x_pos_i, y_pos_i, color_i);
      if (out_valid_o && out_ready_i) sb.check_result(status_o, address_o, stored_word_o);
    end
  end

  // present one pixel word; valid stays up after acceptance for back-to-back
  task automatic send_pixel(coord_t x, coord_t y, logic [31:0] color);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_pos_i    <= x;
    y_pos_i    <= y;
    color_i    <= color;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [abpw_pkg::CFG_INDEX_W-1:0] index,
                           logic [abpw_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // bits above the register width are junk and must be dropped
  task automatic set_geometry(int width, int count);
    write_reg(abpw_pkg::CFG_ROW_WIDTH, ($urandom() << abpw_pkg::ROW_WIDTH_W) | 32'(width));
    write_reg(abpw_pkg::CFG_PIXEL_COUNT,
              ($urandom() << abpw_pkg::PIXEL_COUNT_W) | 32'(count));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly aim at a few in-range words so blends stack up; some wild coordinates
  function automatic void next_pixel(output coord_t x, output coord_t y,
                                     output logic [31:0] color);
    int       limit;
    int       rw;
    int       pos;
    int       row;
    int       col;
    int       pick;
    bit [7:0] alpha;
    rw    = int'(sb.row_width);
    limit = (int'(sb.pixel_count) > abpw_pkg::DEFAULT_STORE_DEPTH)
            ? abpw_pkg::DEFAULT_STORE_DEPTH : int'(sb.pixel_count);
    if (rw == 0 && limit > 4096) limit = 4096;
    x = coord_t'($urandom());
    y = coord_t'($urandom());
    if (limit > 0 && $urandom_range(0, 99) < 80) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        pos = $urandom_range(0, (limit < 8 ? limit : 8) - 1);
      else if (pick < 70)
        pos = limit - 1 - $urandom_range(0, (limit < 4 ? limit : 4) - 1);
      else
        pos = $urandom_range(0, limit - 1);
      if (rw == 0) begin
        x = coord_t'(pos);
      end else begin
        row = pos / rw;
        col = pos - row * rw;
        if (col > 4095) begin
          col -= rw;
          row++;
        end
        // same position reached through a negative column
        if ($urandom_range(0, 3) == 0 && col - rw >= -4096 && row < 4095) begin
          col -= rw;
          row++;
        end
        if (row <= 4095) begin
          x = coord_t'(col);
          y = coord_t'(row);
        end
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 12)      alpha = abpw_pkg::ALPHA_CLEAR;
    else if (pick < 35) alpha = abpw_pkg::ALPHA_OPAQUE;
    else if (pick < 42) alpha = $urandom_range(0, 1) ? 8'd1 : 8'd254;
    else                alpha = 8'($urandom_range(1, 254));
    color = {24'($urandom()), alpha};
  endfunction

  task automatic run_random(int count);
    coord_t      x;
    coord_t      y;
    logic [31:0] color;
    for (int i = 0; i < count; i++) begin
      // let the pipe run dry once in each phase
      if (i == count / 2) drain();
      next_pixel(x, y, color);
      send_pixel(x, y, color);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at reset geometry (256 wide, full surface)
    send_pixel(0, 0, 32'h11223344);        // blend over cleared word
    send_pixel(0, 0, 32'hAABBCCFF);        // opaque
    send_pixel(0, 0, 32'h10203080);        // blend over opaque word
    send_pixel(0, 0, 32'hFFFFFF01);        // lowest blending alpha
    send_pixel(0, 0, 32'h000000FE);        // highest blending alpha
    send_pixel(5, 3, 32'hDEADBE00);        // alpha zero, nothing written
    send_pixel(255, 255, 32'hFFFFFFFF);    // last word of the surface
    send_pixel(0, 256, 32'h12345678);      // one past the end
    send_pixel(-1, 0, 32'h9ABCDEFF);       // negative position
    send_pixel(4095, 4095, 32'h00000080);  // far past the end
    send_pixel(-4096, -4096, 32'hFFFFFF7F);
    send_pixel(-4096, 16, 32'h80808080);   // negative column, lands on zero
    send_pixel(4095, 0, 32'h0F0F0FFF);
    send_pixel(256, -1, 32'hF0F0F07F);     // negative row, lands on zero
    send_pixel(0, 255, 32'h00000080);
    send_pixel(255, 255, 32'h0000007F);    // blend on the last word
    send_pixel(-1, 1, 32'hFFFFFFFF);
    send_pixel(100, 100, 32'h55AA55AA);
    run_random(150);

    // zero row width: position is the column
    set_geometry(0, 4096);
    run_random(100);

    // smallest surface, after a write to an unused index
    write_reg(CFG_UNUSED, $urandom());
    set_geometry(1, 1);
    run_random(60);

    // long stretch with no gaps on either side
    no_gaps = 1'b1;
    set_geometry(4096, 65536);
    run_random(100);
    no_gaps = 1'b0;

    // registers above range, pixel count beyond the store
    set_geometry(8191, 131071);
    run_random(100);

    // zero pixel count: everything out of range
    set_geometry(0, 0);
    run_random(30);

    // small odd surface, heavy blending
    set_geometry(37, 300);
    run_random(250);

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/abpw_pkg.sv
hdl/abpw_surface.sv
hdl/abpw_blend.sv
hdl/alpha_blend_pixel_writer.sv
test/tb_alpha_blend_pixel_writer.sv
